[rtl/morse_character_keyer_defines.svh]
// ---------------------------------------------------------------------------
// Assertion macros shared by the keyer checker
// ---------------------------------------------------------------------------
`ifndef MORSE_CHARACTER_KEYER_DEFINES_SVH
`define MORSE_CHARACTER_KEYER_DEFINES_SVH

// same-cycle implication, gated off while reset is asserted
`define MCK_ASSERT_NOW(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("keyer assertion failed");

// next-cycle implication, gated off while reset is asserted
`define MCK_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("keyer assertion failed");

`endif

[rtl/mck_pkg.sv]
// ---------------------------------------------------------------------------
// mck_pkg
// Types, register indexes, reset values and code tables of the Morse keyer.
// ---------------------------------------------------------------------------
`default_nettype none

package mck_pkg;

    localparam int TICK_W    = 16;
    localparam int CFG_IDX_W = 3;
    localparam int LEN_W     = 3;
    localparam int MAX_ELEMS = 5;
    localparam int STEP_W    = 4;

    typedef logic [TICK_W-1:0]    tick_t;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    // register indexes
    localparam cfg_idx_t REG_DOT        = 3'd0;
    localparam cfg_idx_t REG_DASH       = 3'd1;
    localparam cfg_idx_t REG_SYMBOL_GAP = 3'd2;
    localparam cfg_idx_t REG_LETTER_GAP = 3'd3;
    localparam cfg_idx_t REG_WORD_GAP   = 3'd4;

    localparam tick_t RST_DOT        = 16'd200;
    localparam tick_t RST_DASH       = 16'd600;
    localparam tick_t RST_SYMBOL_GAP = 16'd200;
    localparam tick_t RST_LETTER_GAP = 16'd400;
    localparam tick_t RST_WORD_GAP   = 16'd800;

    localparam logic [7:0] CHAR_SPACE   = 8'h20;
    localparam logic [7:0] CHAR_0       = 8'h30;
    localparam logic [7:0] CHAR_9       = 8'h39;
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
    localparam logic [7:0] CASE_OFFSET  = 8'd32;

    typedef struct packed {
        tick_t dot;
        tick_t dash;
        tick_t symbol_gap;
        tick_t letter_gap;
        tick_t word_gap;
    } cfg_t;

    // one decoded character: space flag, element count and dash mask (bit i = element i)
    typedef struct packed {
        logic                 is_space;
        logic [LEN_W-1:0]     len;
        logic [MAX_ELEMS-1:0] dash;
    } char_code_t;

    typedef struct packed {
        logic       valid;
        char_code_t code;
    } dec_word_t;

    // {length, dash mask}
    localparam logic [7:0] LETTER_TAB [0:25] = '{
        {3'd2, 5'b00010}, {3'd4, 5'b00001}, {3'd4, 5'b00101}, {3'd3, 5'b00001},
        {3'd1, 5'b00000}, {3'd4, 5'b00100}, {3'd3, 5'b00011}, {3'd4, 5'b00000},
        {3'd2, 5'b00000}, {3'd4, 5'b01110}, {3'd3, 5'b00101}, {3'd4, 5'b00010},
        {3'd2, 5'b00011}, {3'd2, 5'b00001}, {3'd3, 5'b00111}, {3'd4, 5'b00110},
        {3'd4, 5'b01011}, {3'd3, 5'b00010}, {3'd3, 5'b00000}, {3'd1, 5'b00001},
        {3'd3, 5'b00100}, {3'd4, 5'b01000}, {3'd3, 5'b00110}, {3'd4, 5'b01001},
        {3'd4, 5'b01101}, {3'd4, 5'b00011}
    };

    localparam logic [MAX_ELEMS-1:0] DIGIT_TAB [0:9] = '{
        5'b11111, 5'b11110, 5'b11100, 5'b11000, 5'b10000,
        5'b00000, 5'b00001, 5'b00011, 5'b00111, 5'b01111
    };

    // fold case and look up; valid low for characters outside the table
    function automatic dec_word_t lookup_char(input logic [7:0] c);
        logic [7:0] up;
        logic [7:0] entry;
        dec_word_t  r;
        up = c;
        if (c inside {[CHAR_LOWER_A:CHAR_LOWER_Z]})
            up = c - CASE_OFFSET;
        r = '0;
        if (up == CHAR_SPACE)
        begin
            r.valid         = 1'b1;
            r.code.is_space = 1'b1;
        end
        else if (up inside {[CHAR_UPPER_A:CHAR_UPPER_Z]})
        begin
            entry       = LETTER_TAB[5'(up - CHAR_UPPER_A)];
            r.valid     = 1'b1;
            r.code.len  = entry[7:5];
            r.code.dash = entry[4:0];
        end
        else if (up inside {[CHAR_0:CHAR_9]})
        begin
            r.valid     = 1'b1;
            r.code.len  = LEN_W'(MAX_ELEMS);
            r.code.dash = DIGIT_TAB[4'(up - CHAR_0)];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

[rtl/morse_character_keyer.sv]
// ---------------------------------------------------------------------------
// morse_character_keyer
// Turns ASCII characters into Morse keying intervals (level, duration).
// ---------------------------------------------------------------------------
//  channel   handshake               payload
//  input     in_valid / in_stall     char_code
//  output    out_valid / out_stall   pin_level, duration, last_of_char
//  config    cfg_valid / cfg_ready   cfg_index, cfg_data
//
//  A character of n elements gives 2n+1 interval words, a space gives 3, one
//  word per cycle from the element step counter unless stalled; 3 to 11 words.
//  Characters outside the table are dropped at the input port and give no words.
//  The next character waits in the input register and follows without a gap.
//  Reset clears all valid flags and loads the default durations.
//  out_stall holds the output register; the step counter waits behind it.
// ---------------------------------------------------------------------------
`default_nettype none

module morse_character_keyer (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_valid,
    output logic                          in_stall,
    input  wire logic [7:0]               char_code,
    output logic                          out_valid,
    input  wire logic                     out_stall,
    output logic                          pin_level,
    output logic [15:0]                   duration,
    output logic                          last_of_char,
    input  wire logic                     cfg_valid,
    output logic                          cfg_ready,
    input  wire logic [mck_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [mck_pkg::TICK_W-1:0]    cfg_data
);
    import mck_pkg::*;

    cfg_t      cfg_reg;
    cfg_t      cfg_next;
    dec_word_t dec;
    logic      take;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_DOT:        cfg_next.dot        = cfg_data;
                REG_DASH:       cfg_next.dash       = cfg_data;
                REG_SYMBOL_GAP: cfg_next.symbol_gap = cfg_data;
                REG_LETTER_GAP: cfg_next.letter_gap = cfg_data;
                REG_WORD_GAP:   cfg_next.word_gap   = cfg_data;
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.dot        <= RST_DOT;
            cfg_reg.dash       <= RST_DASH;
            cfg_reg.symbol_gap <= RST_SYMBOL_GAP;
            cfg_reg.letter_gap <= RST_LETTER_GAP;
            cfg_reg.word_gap   <= RST_WORD_GAP;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    mck_decode u_decode (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .char_code (char_code),
        .take      (take),
        .dec       (dec)
    );

    mck_emit u_emit (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .dec          (dec),
        .take         (take),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .pin_level    (pin_level),
        .duration     (duration),
        .last_of_char (last_of_char)
    );

endmodule

`default_nettype wire

[rtl/mck_decode.sv]
// ---------------------------------------------------------------------------
// mck_decode
// Input register: folds case, looks the character up, holds the code.
// ---------------------------------------------------------------------------
`default_nettype none

module mck_decode (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [7:0]         char_code,
    input  wire logic               take,
    output mck_pkg::dec_word_t      dec
);
    import mck_pkg::*;

    logic       valid_reg;
    logic       valid_next;
    char_code_t code_reg;
    char_code_t code_next;
    dec_word_t  lookup;
    logic       accept;

    assign in_stall = valid_reg && !take;
    assign accept   = in_valid && !in_stall;
    assign lookup   = lookup_char(char_code);

    always_comb
    begin
        valid_next = valid_reg;
        code_next  = code_reg;
        if (accept)
        begin
            // drop characters outside the table right here
            valid_next = lookup.valid;
            code_next  = lookup.code;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        code_reg <= code_next;
    end

    assign dec.valid = valid_reg;
    assign dec.code  = code_reg;

endmodule

`default_nettype wire

[rtl/mck_emit.sv]
// ---------------------------------------------------------------------------
// mck_emit
// Steps through the elements of one character into the output register,
// one interval word a cycle unless out_stall holds that register.
// ---------------------------------------------------------------------------
`default_nettype none

module mck_emit (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire mck_pkg::cfg_t      cfg,
    input  wire mck_pkg::dec_word_t dec,
    output logic                    take,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic                    pin_level,
    output logic [15:0]             duration,
    output logic                    last_of_char
);
    import mck_pkg::*;

    logic              active_reg;
    logic              active_next;
    char_code_t        code_reg;
    char_code_t        code_next;
    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic              pin_reg;
    logic              pin_next;
    tick_t             dur_reg;
    tick_t             dur_next;
    logic              last_reg;
    logic              last_next;

    logic              out_free;
    logic              emit;
    logic              cur_last;
    logic              cur_pin;
    tick_t             cur_dur;
    logic [LEN_W-1:0]  elem;

    assign out_free = !out_valid_reg || !out_stall;
    assign emit     = active_reg && out_free;
    assign elem     = step_reg[STEP_W-1:1];

    // current interval from the step count
    always_comb
    begin
        cur_pin  = 1'b0;
        cur_dur  = cfg.symbol_gap;
        cur_last = 1'b0;
        if (code_reg.is_space)
        begin
            cur_last = (step_reg == STEP_W'(2));
            if (step_reg == STEP_W'(1))
                cur_dur = cfg.letter_gap;
            else if (step_reg == STEP_W'(2))
                cur_dur = cfg.word_gap;
        end
        else if (step_reg == {code_reg.len, 1'b0})
        begin
            cur_last = 1'b1;
            cur_dur  = cfg.letter_gap;
        end
        else if (!step_reg[0])
        begin
            cur_pin = 1'b1;
            cur_dur = code_reg.dash[elem] ? cfg.dash : cfg.dot;
        end
    end

    // load the next character when idle, or as the last word of this one goes out
    assign take = dec.valid && (!active_reg || (emit && cur_last));

    always_comb
    begin
        active_next    = active_reg;
        code_next      = code_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg;
        pin_next       = pin_reg;
        dur_next       = dur_reg;
        last_next      = last_reg;

        if (emit)
        begin
            out_valid_next = 1'b1;
            pin_next       = cur_pin;
            dur_next       = cur_dur;
            last_next      = cur_last;
            step_next      = step_reg + STEP_W'(1);
            if (cur_last)
                active_next = 1'b0;
        end
        else if (out_free)
        begin
            out_valid_next = 1'b0;
        end

        if (take)
        begin
            active_next = 1'b1;
            code_next   = dec.code;
            step_next   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            active_reg    <= active_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        code_reg <= code_next;
        pin_reg  <= pin_next;
        dur_reg  <= dur_next;
        last_reg <= last_next;
    end

    assign out_valid    = out_valid_reg;
    assign pin_level    = pin_reg;
    assign duration     = dur_reg;
    assign last_of_char = last_reg;

endmodule

`default_nettype wire

[rtl/mck_checker.sv]
// ---------------------------------------------------------------------------
// mck_checker
// Port-level checks of the keyer's interval stream.
// ---------------------------------------------------------------------------
`default_nettype none

`include "morse_character_keyer_defines.svh"

module mck_checker (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     out_valid,
    input  wire logic                     out_stall,
    input  wire logic                     pin_level,
    input  wire logic                     last_of_char
);

    // hold a stalled word
    `MCK_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid)

    // a character's words come back to back until its last one
    `MCK_ASSERT_NEXT(a_run_unbroken, clk, rst_n, out_valid && !out_stall && !last_of_char, out_valid)

    // every mark is followed by a low symbol gap
    `MCK_ASSERT_NEXT(a_mark_then_gap, clk, rst_n, out_valid && !out_stall && pin_level, out_valid && !pin_level)

    // a character never ends on a mark
    `MCK_ASSERT_NOW(a_last_is_low, clk, rst_n, out_valid && pin_level, !last_of_char)

endmodule

bind morse_character_keyer mck_checker u_mck_checker (.*);

`default_nettype wire
